[design/vtlp_pkg.sv]
// Shared types and constants of the vertex transform, light and projection unit.
`timescale 1ns / 1ps
package vtlp_pkg;

  localparam int unsigned VIEW_FRAC  = 8;
  localparam int unsigned LIGHT_FRAC = 14;
  // quotient bits resolved by the divider row; larger quotients saturate anyway
  localparam int unsigned QUO_W      = 25;
  // dividend magnitude width, sized for the widest subpixel setting
  localparam int unsigned NUM_W      = 56;
  localparam int unsigned DIV_W      = 31;

  localparam int unsigned CLIP_LEFT   = 0;
  localparam int unsigned CLIP_RIGHT  = 1;
  localparam int unsigned CLIP_TOP    = 2;
  localparam int unsigned CLIP_BOTTOM = 3;
  localparam int unsigned CLIP_NEAR   = 4;

  localparam logic [7:0]         INTEN_MAX = 8'd128;
  localparam logic signed [33:0] LIGHT_ONE = 34'sd268435456;

  typedef logic [NUM_W-1:0] rem_t;
  typedef logic [QUO_W-1:0] quo_t;
  typedef logic [DIV_W-1:0] divisor_t;

  typedef enum logic [2:0] {
    REG_MATRIX_X = 3'd0,
    REG_MATRIX_Y = 3'd1,
    REG_MATRIX_Z = 3'd2,
    REG_LIGHT    = 3'd3,
    REG_GEOMETRY = 3'd4,
    REG_SIZE     = 3'd5,
    REG_LIGHT_EN = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] view_x;
    logic signed [31:0] view_y;
    logic signed [31:0] view_z;
    logic               near;
    logic               lit;
    logic [7:0]         intensity;
    logic signed [27:0] depth_key;
    logic               last;
  } side_t;

  typedef struct packed {
    rem_t rem;
    quo_t quo;
    logic neg;
    logic ovf;
  } div_lane_t;

  typedef struct packed {
    div_lane_t lane_x;
    div_lane_t lane_y;
    divisor_t  divisor;
    side_t     side;
  } cell_item_t;

endpackage

[design/vertex_transform_light_project_top.sv]
// Top level of the vertex transform, light and projection unit.
`timescale 1ns / 1ps
// Usage:
//   Input channel: one vertex and its normal per item, taken when in_valid_i
//   is high and in_stall_o is low. Output channel: one result per item,
//   taken when out_valid_o is high and out_stall_i is low, in input order.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at the
//   clock edge; unknown indexes are dropped. Write only while no item is in
//   flight.
//   Stages: 4 front stages, one cell per quotient bit in a row of 25 divider
//   cells, one output register.
//   Throughput: one item per cycle while the output is not stalled; every
//   stage is a register with its own valid bit, so bubbles collapse and the
//   divider row takes a new dividend each cycle.
//   Stall: a stalled result holds in the output register; the stages behind
//   it keep filling and the input stalls only when every stage is full.
//   Reset: clears the configuration registers and all valid bits; no item is in flight after it.
module vertex_transform_light_project_top #(
  parameter int unsigned COEF_FRAC_BITS = 14,
  parameter int unsigned SUBPIXEL_BITS  = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] vertex_x_i,
  input  logic signed [15:0] vertex_y_i,
  input  logic signed [15:0] vertex_z_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic               last_vertex_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] screen_x_o,
  output logic signed [23:0] screen_y_o,
  output logic signed [31:0] view_x_o,
  output logic signed [31:0] view_y_o,
  output logic signed [31:0] view_z_o,
  output logic [4:0]         clip_code_o,
  output logic               lit_o,
  output logic [7:0]         intensity_o,
  output logic signed [27:0] depth_key_o,
  output logic               last_out_o
);

  localparam int unsigned NCELL = vtlp_pkg::QUO_W;

  logic [63:0] row_x_q, row_y_q, row_z_q, light_q, geometry_q;
  logic [31:0] size_q;
  logic        light_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_x_q    <= '0;
      row_y_q    <= '0;
      row_z_q    <= '0;
      light_q    <= '0;
      geometry_q <= '0;
      size_q     <= '0;
      light_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vtlp_pkg::REG_MATRIX_X: row_x_q    <= cfg_data_i;
        vtlp_pkg::REG_MATRIX_Y: row_y_q    <= cfg_data_i;
        vtlp_pkg::REG_MATRIX_Z: row_z_q    <= cfg_data_i;
        vtlp_pkg::REG_LIGHT:    light_q    <= cfg_data_i;
        vtlp_pkg::REG_GEOMETRY: geometry_q <= cfg_data_i;
        vtlp_pkg::REG_SIZE:     size_q     <= cfg_data_i[31:0];
        vtlp_pkg::REG_LIGHT_EN: light_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic                 ch_valid [NCELL+1];
  logic                 ch_ready [NCELL+1];
  vtlp_pkg::cell_item_t ch_item  [NCELL+1];
  logic                 in_ready;

  assign in_stall_o = !in_ready;

  vtlp_front #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .SUBPIXEL_BITS (SUBPIXEL_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready),
    .vertex_x_i   (vertex_x_i),
    .vertex_y_i   (vertex_y_i),
    .vertex_z_i   (vertex_z_i),
    .normal_x_i   (normal_x_i),
    .normal_y_i   (normal_y_i),
    .normal_z_i   (normal_z_i),
    .last_vertex_i(last_vertex_i),
    .row_x_i      (row_x_q),
    .row_y_i      (row_y_q),
    .row_z_i      (row_z_q),
    .light_i      (light_q),
    .geometry_i   (geometry_q),
    .light_en_i   (light_en_q),
    .out_valid_o  (ch_valid[0]),
    .out_ready_i  (ch_ready[0]),
    .out_item_o   (ch_item[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    vtlp_div_cell #(
      .BIT_POS(NCELL - 1 - i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (ch_valid[i]),
      .in_ready_o (ch_ready[i]),
      .in_item_i  (ch_item[i]),
      .out_valid_o(ch_valid[i+1]),
      .out_ready_i(ch_ready[i+1]),
      .out_item_o (ch_item[i+1])
    );
  end

  // output stage: signed quotient, center offset, clip tests, saturation
  vtlp_pkg::cell_item_t fin;
  logic [25:0]          qmx, qmy;
  logic signed [27:0]   qx, qy, px, py, wlim, hlim;
  logic signed [23:0]   sx, sy;
  logic [4:0]           clip;
  logic                 out_valid_q;
  logic                 out_ready;

  assign fin       = ch_item[NCELL];
  assign out_ready = !out_valid_q || !out_stall_i;
  assign ch_ready[NCELL] = out_ready;

  always_comb begin
    qmx  = fin.lane_x.ovf ? (26'd1 << vtlp_pkg::QUO_W) : {1'b0, fin.lane_x.quo};
    qmy  = fin.lane_y.ovf ? (26'd1 << vtlp_pkg::QUO_W) : {1'b0, fin.lane_y.quo};
    qx   = fin.lane_x.neg ? -$signed({2'b0, qmx}) : $signed({2'b0, qmx});
    qy   = fin.lane_y.neg ? -$signed({2'b0, qmy}) : $signed({2'b0, qmy});
    px   = $signed({12'b0, geometry_q[15:0]}) + qx;
    py   = $signed({12'b0, geometry_q[31:16]}) - qy;
    wlim = $signed(28'({12'b0, size_q[15:0]}) << SUBPIXEL_BITS);
    hlim = $signed(28'({12'b0, size_q[31:16]}) << SUBPIXEL_BITS);
    clip = '0;
    if (fin.side.near) begin
      px = '0;
      py = '0;
      clip[vtlp_pkg::CLIP_NEAR] = 1'b1;
    end else begin
      clip[vtlp_pkg::CLIP_LEFT]   = px < 28'sd0;
      clip[vtlp_pkg::CLIP_RIGHT]  = px > wlim;
      clip[vtlp_pkg::CLIP_TOP]    = py < 28'sd0;
      clip[vtlp_pkg::CLIP_BOTTOM] = py > hlim;
    end
    if (px > 28'sd8388607)       sx = 24'sh7FFFFF;
    else if (px < -28'sd8388608) sx = 24'sh800000;
    else                         sx = px[23:0];
    if (py > 28'sd8388607)       sy = 24'sh7FFFFF;
    else if (py < -28'sd8388608) sy = 24'sh800000;
    else                         sy = py[23:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= ch_valid[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && ch_valid[NCELL]) begin
      screen_x_o  <= sx;
      screen_y_o  <= sy;
      view_x_o    <= fin.side.view_x;
      view_y_o    <= fin.side.view_y;
      view_z_o    <= fin.side.view_z;
      clip_code_o <= clip;
      lit_o       <= fin.side.lit;
      intensity_o <= fin.side.intensity;
      depth_key_o <= fin.side.depth_key;
      last_out_o  <= fin.side.last;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_near_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clip_code_o[vtlp_pkg::CLIP_NEAR] |->
      screen_x_o == 24'sd0 && screen_y_o == 24'sd0 && clip_code_o[3:0] == 4'd0)
    else $error("near vertex with nonzero screen position or edge bits");

  a_unlit_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !lit_o |-> intensity_o == 8'd0)
    else $error("intensity without lit flag");

  a_inten_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> intensity_o <= vtlp_pkg::INTEN_MAX)
    else $error("intensity above full scale");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output not blocked");
`endif

endmodule

[design/vtlp_front.sv]
// Front pipeline: view matrix, lighting, projection products and divider setup.
`timescale 1ns / 1ps
module vtlp_front #(
  parameter int unsigned COEF_FRAC_BITS = 14,
  parameter int unsigned SUBPIXEL_BITS  = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [15:0]       vertex_x_i,
  input  logic signed [15:0]       vertex_y_i,
  input  logic signed [15:0]       vertex_z_i,
  input  logic signed [15:0]       normal_x_i,
  input  logic signed [15:0]       normal_y_i,
  input  logic signed [15:0]       normal_z_i,
  input  logic                     last_vertex_i,
  input  logic [63:0]              row_x_i,
  input  logic [63:0]              row_y_i,
  input  logic [63:0]              row_z_i,
  input  logic [63:0]              light_i,
  input  logic [63:0]              geometry_i,
  input  logic                     light_en_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output vtlp_pkg::cell_item_t     out_item_o
);

  localparam int unsigned SHIFT = COEF_FRAC_BITS - vtlp_pkg::VIEW_FRAC;
  localparam int unsigned INTEN_SHIFT = 2 * vtlp_pkg::LIGHT_FRAC - 7;

  logic [3:0] v_q;
  logic [3:0] rdy;

  assign rdy[3] = !v_q[3] || out_ready_i;
  assign rdy[2] = !v_q[2] || rdy[3];
  assign rdy[1] = !v_q[1] || rdy[2];
  assign rdy[0] = !v_q[0] || rdy[1];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
    end
  end

  // stage 1: coefficient products
  logic [63:0]        rows [3];
  logic signed [15:0] vin  [3];
  logic signed [15:0] nin  [3];
  logic signed [31:0] pr1_q [3][3];
  logic signed [31:0] nl1_q [3];
  logic               last1_q;

  assign rows[0] = row_x_i;
  assign rows[1] = row_y_i;
  assign rows[2] = row_z_i;
  assign vin[0]  = vertex_x_i;
  assign vin[1]  = vertex_y_i;
  assign vin[2]  = vertex_z_i;
  assign nin[0]  = normal_x_i;
  assign nin[1]  = normal_y_i;
  assign nin[2]  = normal_z_i;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pr1_q[r][c] <= vin[c] * $signed(rows[r][16*c +: 16]);
        end
      end
      for (int c = 0; c < 3; c++) begin
        nl1_q[c] <= nin[c] * $signed(light_i[16*c +: 16]);
      end
      last1_q <= last_vertex_i;
    end
  end

  // stage 2: sums, floor shift, saturation, illumination
  logic signed [35:0] acc [3];
  logic signed [35:0] shf [3];
  logic signed [31:0] vw  [3];
  logic signed [33:0] il;
  logic               lit2;
  logic [7:0]         inten2;
  logic signed [31:0] w2_q [3];
  logic               lit2_q;
  logic [7:0]         inten2_q;
  logic               last2_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 36'(pr1_q[r][0]) + 36'(pr1_q[r][1]) + 36'(pr1_q[r][2]) +
               (36'($signed(rows[r][63:48])) <<< COEF_FRAC_BITS);
      shf[r] = acc[r] >>> SHIFT;
      if (shf[r] > 36'sd2147483647) begin
        vw[r] = 32'sh7FFFFFFF;
      end else if (shf[r] < -36'sd2147483648) begin
        vw[r] = 32'sh80000000;
      end else begin
        vw[r] = shf[r][31:0];
      end
    end
    il = (34'($signed(light_i[63:48])) <<< vtlp_pkg::LIGHT_FRAC) +
         34'(nl1_q[0]) + 34'(nl1_q[1]) + 34'(nl1_q[2]);
    lit2   = light_en_i && (il > 34'sd0);
    inten2 = '0;
    if (lit2) begin
      if (il > vtlp_pkg::LIGHT_ONE) inten2 = vtlp_pkg::INTEN_MAX;
      else                          inten2 = il[INTEN_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1] && v_q[0]) begin
      w2_q     <= vw;
      lit2_q   <= lit2;
      inten2_q <= inten2;
      last2_q  <= last1_q;
    end
  end

  // stage 3: projection products, depth key, near test
  logic signed [32:0] dk_sum;
  logic signed [48:0] m3x_q, m3y_q;
  vtlp_pkg::side_t    side3_q;

  assign dk_sum = 33'(w2_q[2]) + (w2_q[2][31] ? 33'sd15 : 33'sd0);

  always_ff @(posedge clk_i) begin
    if (rdy[2] && v_q[1]) begin
      m3x_q             <= w2_q[0] * $signed({1'b0, geometry_i[47:32]});
      m3y_q             <= w2_q[1] * $signed({1'b0, geometry_i[63:48]});
      side3_q.view_x    <= w2_q[0];
      side3_q.view_y    <= w2_q[1];
      side3_q.view_z    <= w2_q[2];
      side3_q.near      <= w2_q[2] < 32'sd256;
      side3_q.lit       <= lit2_q;
      side3_q.intensity <= inten2_q;
      side3_q.depth_key <= dk_sum[31:4];
      side3_q.last      <= last2_q;
    end
  end

  // stage 4: dividend magnitudes and quotient overflow check
  logic [48:0]          magx49, magy49;
  vtlp_pkg::rem_t       magx, magy, dvs;
  vtlp_pkg::cell_item_t item4_q;

  always_comb begin
    magx49 = m3x_q[48] ? 49'(-m3x_q) : 49'(m3x_q);
    magy49 = m3y_q[48] ? 49'(-m3y_q) : 49'(m3y_q);
    magx   = vtlp_pkg::rem_t'(magx49) << SUBPIXEL_BITS;
    magy   = vtlp_pkg::rem_t'(magy49) << SUBPIXEL_BITS;
    dvs    = vtlp_pkg::rem_t'(side3_q.view_z[30:0]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3] && v_q[2]) begin
      item4_q.lane_x.rem <= magx;
      item4_q.lane_x.quo <= '0;
      item4_q.lane_x.neg <= m3x_q[48] ^ side3_q.view_z[31];
      item4_q.lane_x.ovf <= (magx >> vtlp_pkg::QUO_W) >= dvs;
      item4_q.lane_y.rem <= magy;
      item4_q.lane_y.quo <= '0;
      item4_q.lane_y.neg <= m3y_q[48] ^ side3_q.view_z[31];
      item4_q.lane_y.ovf <= (magy >> vtlp_pkg::QUO_W) >= dvs;
      item4_q.divisor    <= side3_q.view_z[30:0];
      item4_q.side       <= side3_q;
    end
  end

  assign out_item_o = item4_q;

endmodule

[design/vtlp_div_cell.sv]
// One restoring-division cell: resolves a single quotient bit for both lanes.
`timescale 1ns / 1ps
module vtlp_div_cell #(
  parameter int unsigned BIT_POS = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  vtlp_pkg::cell_item_t in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output vtlp_pkg::cell_item_t out_item_o
);

  logic                 valid_q;
  vtlp_pkg::cell_item_t item_q, item_d;
  vtlp_pkg::rem_t       sub;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_comb begin
    item_d = in_item_i;
    sub    = vtlp_pkg::rem_t'(in_item_i.divisor) << BIT_POS;
    if (in_item_i.lane_x.rem >= sub) begin
      item_d.lane_x.rem          = in_item_i.lane_x.rem - sub;
      item_d.lane_x.quo[BIT_POS] = 1'b1;
    end
    if (in_item_i.lane_y.rem >= sub) begin
      item_d.lane_y.rem          = in_item_i.lane_y.rem - sub;
      item_d.lane_y.quo[BIT_POS] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) item_q <= item_d;
  end

endmodule

[sim/testbench.sv]
// Self-checking testbench of the vertex transform, light and projection unit.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic signed [23:0] screen_x;
    logic signed [23:0] screen_y;
    logic signed [31:0] view_x;
    logic signed [31:0] view_y;
    logic signed [31:0] view_z;
    logic [4:0]         clip_code;
    logic               lit;
    logic [7:0]         intensity;
    logic signed [27:0] depth_key;
    logic               last;
  } vertex_result_t;

  class vertex_scoreboard;
    logic [63:0] row_x, row_y, row_z, light, geom, size;
    logic        light_en;
    vertex_result_t pending[$];
    int errors;

    function new();
      row_x = 0; row_y = 0; row_z = 0; light = 0; geom = 0; size = 0;
      light_en = 0; errors = 0;
    endfunction

    function void write_reg(vtlp_pkg::cfg_reg_e idx, logic [63:0] data);
      case (idx)
        vtlp_pkg::REG_MATRIX_X: row_x = data;
        vtlp_pkg::REG_MATRIX_Y: row_y = data;
        vtlp_pkg::REG_MATRIX_Z: row_z = data;
        vtlp_pkg::REG_LIGHT:    light = data;
        vtlp_pkg::REG_GEOMETRY: geom = data;
        vtlp_pkg::REG_SIZE:     size = {32'd0, data[31:0]};
        vtlp_pkg::REG_LIGHT_EN: light_en = data[0];
        default: ;
      endcase
    endfunction

    function longint s16(logic [63:0] v, int pos);
      logic signed [15:0] f;
      f = v[pos +: 16];
      return longint'(f);
    endfunction

    function longint clamp(longint v, int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function longint transform(logic [63:0] row, longint x, longint y, longint z);
      longint acc;
      acc = x * s16(row, 0) + y * s16(row, 16) + z * s16(row, 32) + (s16(row, 48) <<< 14);
      return clamp(acc >>> 6, 32);  // arithmetic shift floors
    endfunction

    function void note_vertex(longint vx, longint vy, longint vz,
                              longint nx, longint ny, longint nz, logic last);
      vertex_result_t r;
      longint wx, wy, wz, px, py, il, low;
      wx = transform(row_x, vx, vy, vz);
      wy = transform(row_y, vx, vy, vz);
      wz = transform(row_z, vx, vy, vz);
      px = 0; py = 0;
      r.clip_code = 0;
      if (wz < 256) begin
        r.clip_code[vtlp_pkg::CLIP_NEAR] = 1;
      end else begin
        px = longint'(geom[15:0]) + (wx * longint'(geom[47:32]) * 16) / wz;
        py = longint'(geom[31:16]) - (wy * longint'(geom[63:48]) * 16) / wz;
        r.clip_code[vtlp_pkg::CLIP_LEFT]   = px < 0;
        r.clip_code[vtlp_pkg::CLIP_RIGHT]  = px > longint'(size[15:0]) * 16;
        r.clip_code[vtlp_pkg::CLIP_TOP]    = py < 0;
        r.clip_code[vtlp_pkg::CLIP_BOTTOM] = py > longint'(size[31:16]) * 16;
      end
      r.lit = 0; r.intensity = 0;
      if (light_en) begin
        low = -(longint'(1) <<< 28) * 3 / 5;
        il = (s16(light, 48) <<< 14) + nx * s16(light, 0) + ny * s16(light, 16)
             + nz * s16(light, 32);
        if (il < low) il = low;
        else if (il > (longint'(1) <<< 28)) il = longint'(1) <<< 28;
        if (il > 0) begin
          r.lit = 1;
          r.intensity = 8'(il >>> 21);
        end
      end
      r.screen_x = 24'(clamp(px, 24));
      r.screen_y = 24'(clamp(py, 24));
      r.view_x = 32'(wx);
      r.view_y = 32'(wy);
      r.view_z = 32'(wz);
      r.depth_key = 28'(wz / 16);
      r.last = last;
      pending.push_back(r);
    endfunction

    function void check_result(vertex_result_t a);
      vertex_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.screen_x !== e.screen_x) begin
        $error("screen_x exp %0d got %0d", e.screen_x, a.screen_x); errors++; end
      if (a.screen_y !== e.screen_y) begin
        $error("screen_y exp %0d got %0d", e.screen_y, a.screen_y); errors++; end
      if (a.view_x !== e.view_x) begin
        $error("view_x exp %0d got %0d", e.view_x, a.view_x); errors++; end
      if (a.view_y !== e.view_y) begin
        $error("view_y exp %0d got %0d", e.view_y, a.view_y); errors++; end
      if (a.view_z !== e.view_z) begin
        $error("view_z exp %0d got %0d", e.view_z, a.view_z); errors++; end
      if (a.clip_code !== e.clip_code) begin
        $error("clip_code exp %0h got %0h", e.clip_code, a.clip_code); errors++; end
      if (a.lit !== e.lit) begin
        $error("lit exp %0d got %0d", e.lit, a.lit); errors++; end
      if (a.intensity !== e.intensity) begin
        $error("intensity exp %0d got %0d", e.intensity, a.intensity); errors++; end
      if (a.depth_key !== e.depth_key) begin
        $error("depth_key exp %0d got %0d", e.depth_key, a.depth_key); errors++; end
      if (a.last !== e.last) begin
        $error("last_out exp %0d got %0d", e.last, a.last); errors++; end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [63:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic signed [15:0] vertex_x_i, vertex_y_i, vertex_z_i;
  logic signed [15:0] normal_x_i, normal_y_i, normal_z_i;
  logic last_vertex_i;
  logic out_valid_o, out_stall_i;
  logic signed [23:0] screen_x_o, screen_y_o;
  logic signed [31:0] view_x_o, view_y_o, view_z_o;
  logic [4:0] clip_code_o;
  logic lit_o;
  logic [7:0] intensity_o;
  logic signed [27:0] depth_key_o;
  logic last_out_o;

  vertex_transform_light_project_top DUT (.*);

  vertex_scoreboard board;
  int idle_pct;  // percentage of idle cycles on both sides

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  // result sink: stall changes at the falling edge, sample at the rising edge
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk_i) begin
    vertex_result_t a;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      a.screen_x = screen_x_o; a.screen_y = screen_y_o;
      a.view_x = view_x_o; a.view_y = view_y_o; a.view_z = view_z_o;
      a.clip_code = clip_code_o; a.lit = lit_o; a.intensity = intensity_o;
      a.depth_key = depth_key_o; a.last = last_out_o;
      board.check_result(a);
    end
  end

  // drop input valid and wait until every item has left the block
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(vtlp_pkg::cfg_reg_e idx, logic [63:0] data);
    @(negedge clk_i);
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    board.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  // present one vertex at a falling edge and hold it until accepted
  task automatic send_vertex(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
                             logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                             logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    vertex_x_i <= vx; vertex_y_i <= vy; vertex_z_i <= vz;
    normal_x_i <= nx; normal_y_i <= ny; normal_z_i <= nz;
    last_vertex_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_vertex(longint'($signed(vx)), longint'($signed(vy)), longint'($signed(vz)),
                      longint'($signed(nx)), longint'($signed(ny)), longint'($signed(nz)),
                      last);
  endtask

  function automatic logic [15:0] rand_normal();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(32768)) - 16384);
      default: return 16'($signed($urandom_range(2048)) - 1024);
    endcase
  endfunction

  // random but mostly sensible view setup: depth mostly in front of the eye
  task automatic random_setup(bit wild);
    logic [63:0] v;
    v = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
    write_reg(vtlp_pkg::REG_MATRIX_X, wild ? {$urandom, $urandom} : v);
    v = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
    write_reg(vtlp_pkg::REG_MATRIX_Y, wild ? {$urandom, $urandom} : v);
    v = {16'($urandom_range(4000)), rand_coef(), rand_coef(), rand_coef()};
    write_reg(vtlp_pkg::REG_MATRIX_Z, wild ? {$urandom, $urandom} : v);
    write_reg(vtlp_pkg::REG_LIGHT,
              {rand_normal(), rand_normal(), rand_normal(), rand_normal()});
    write_reg(vtlp_pkg::REG_GEOMETRY, wild ? {$urandom, $urandom} :
              {16'($urandom_range(600)), 16'($urandom_range(600)),
               16'($urandom_range(5120)), 16'($urandom_range(5120))});
    write_reg(vtlp_pkg::REG_SIZE, wild ? {$urandom, $urandom} :
              {32'd0, 16'($urandom_range(480)), 16'($urandom_range(640))});
    write_reg(vtlp_pkg::REG_LIGHT_EN, 64'($urandom_range(3) != 0));
  endtask

  task automatic random_vertex(bit small_coords);
    logic [15:0] vx, vy, vz;
    if (small_coords) begin
      vx = 16'($signed($urandom_range(2000)) - 1000);
      vy = 16'($signed($urandom_range(2000)) - 1000);
      vz = 16'($signed($urandom_range(2000)) - 1000);
    end else begin
      vx = 16'($urandom); vy = 16'($urandom); vz = 16'($urandom);
    end
    if ($urandom_range(9) == 0)
      send_vertex(vx, vy, vz, 16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom_range(1));
    else
      send_vertex(vx, vy, vz, rand_normal(), rand_normal(), rand_normal(),
                  $urandom_range(7) == 0);
  endtask

  initial begin
    board = new();
    idle_pct = 38;
    rst_ni = 0;
    cfg_we_i = 0; cfg_idx_i = vtlp_pkg::REG_MATRIX_X; cfg_data_i = 0;
    in_valid_i = 0; out_stall_i = 0;
    vertex_x_i = 0; vertex_y_i = 0; vertex_z_i = 0;
    normal_x_i = 0; normal_y_i = 0; normal_z_i = 0; last_vertex_i = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // all-zero registers: every vertex is near-clipped and unlit
    send_vertex(16'h7fff, 16'h8000, 16'h0000, 16'h4000, 16'hc000, 16'h0000, 1);

    // identity-ish view, depth pushed forward, full lighting
    write_reg(vtlp_pkg::REG_MATRIX_X, {16'd0, 16'd0, 16'd0, 16'h4000});
    write_reg(vtlp_pkg::REG_MATRIX_Y, {16'd0, 16'd0, 16'h4000, 16'd0});
    write_reg(vtlp_pkg::REG_MATRIX_Z, {16'd100, 16'h4000, 16'd0, 16'd0});
    write_reg(vtlp_pkg::REG_LIGHT, {16'd0, 16'h4000, 16'd0, 16'd0});
    write_reg(vtlp_pkg::REG_GEOMETRY, {16'd256, 16'd256, 16'd3840, 16'd5120});
    write_reg(vtlp_pkg::REG_SIZE, {32'd0, 16'd480, 16'd640});
    write_reg(vtlp_pkg::REG_LIGHT_EN, 64'd1);
    send_vertex(0, 0, 0, 0, 0, 16'h4000, 0);          // centered, full light
    send_vertex(0, 0, -16'sd100, 0, 0, 16'h4000, 0);  // depth exactly zero: near
    send_vertex(0, 0, -16'sd99, 0, 0, 16'hc000, 0);   // depth exactly one, dark
    send_vertex(0, 0, -16'sd101, 0, 0, 16'd1, 0);     // just behind, tiny light
    send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 16'h4000, 0);
    send_vertex(16'h8000, 16'h8000, 16'h7fff, 0, 0, 16'h8000, 0);
    send_vertex(16'h8000, 16'h7fff, 16'd10, 16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_vertex(16'd100, -16'd100, 16'd0, 0, 0, 16'd2, 0);
    send_vertex(-16'd100, 16'd100, 16'd0, 0, 0, 16'd0, 1);
    // edge checks: the first vertex lies exactly on every edge
    write_reg(vtlp_pkg::REG_GEOMETRY, {16'd0, 16'd0, 16'd0, 16'd0});
    write_reg(vtlp_pkg::REG_SIZE, {32'd0, 16'd0, 16'd0});
    send_vertex(0, 0, 0, 0, 0, 0, 0);               // exactly on every edge
    write_reg(vtlp_pkg::REG_GEOMETRY, {16'd256, 16'd256, 16'd1, 16'd1});
    write_reg(vtlp_pkg::REG_SIZE, {32'd0, 16'd16, 16'd16});
    send_vertex(16'd100, 16'd100, 0, 0, 0, 0, 0);
    send_vertex(-16'd100, -16'd100, 0, 0, 0, 0, 0);
    // extremes of all registers, lighting still on
    write_reg(vtlp_pkg::REG_MATRIX_X, 64'hffff_ffff_ffff_ffff);
    write_reg(vtlp_pkg::REG_MATRIX_Y, 64'h7fff_7fff_7fff_7fff);
    write_reg(vtlp_pkg::REG_MATRIX_Z, 64'h7fff_8000_8000_8000);
    write_reg(vtlp_pkg::REG_LIGHT, 64'h8000_8000_8000_8000);
    write_reg(vtlp_pkg::REG_GEOMETRY, 64'hffff_ffff_ffff_ffff);
    write_reg(vtlp_pkg::REG_SIZE, 64'hffff_ffff_ffff_ffff);
    send_vertex(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1);
    send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
    write_reg(vtlp_pkg::REG_LIGHT_EN, 64'hffff_ffff_ffff_fffe);  // only bit 0 counts
    send_vertex(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1);
    write_reg(vtlp_pkg::REG_LIGHT_EN, 64'd1);
    send_vertex(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1);
    send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
    drain();
    // unknown index: dropped
    write_reg(vtlp_pkg::cfg_reg_e'(3'd7), 64'h1234);

    // random phases; one phase runs without idling
    for (int phase = 0; phase < 12; phase++) begin
      idle_pct = (phase == 5) ? 0 : 38;
      random_setup(phase % 4 == 3);
      for (int n = 0; n < 110; n++) begin
        random_vertex($urandom_range(3) != 0);
        if (n == 50) drain();
      end
      drain();
    end
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
